/* hw/rtl/rts_pkg.sv */
// Package: shared types, constants and helpers for the ray/tetrahedron slab test.
`default_nettype none
package rts_pkg;

   localparam int FRAC_BITS = 16;
   localparam int Q_W = 32;
   localparam int NUM_W = Q_W + FRAC_BITS;
   localparam int LANES = 4;
   localparam int LANE_DEPTH = NUM_W + 5;
   localparam int STAGES = LANE_DEPTH + 2;
   localparam int CSR_COUNT = 8;
   localparam int CSR_IDX_W = 4;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic signed [Q_W-1:0] orig_x;
      logic signed [Q_W-1:0] orig_y;
      logic signed [Q_W-1:0] orig_z;
      logic signed [Q_W-1:0] orig_w;
      logic signed [Q_W-1:0] dir_x;
      logic signed [Q_W-1:0] dir_y;
      logic signed [Q_W-1:0] dir_z;
      logic signed [Q_W-1:0] dir_w;
   } ray_in_type;

   typedef struct packed {
      logic signed [Q_W-1:0] cut_length;
      logic                  saturated;
   } ray_out_type;

   typedef struct packed {
      logic signed [Q_W-1:0] q;
      logic                  dneg;
      logic                  flag;
   } lane_res_type;

   typedef struct packed {
      logic qneg;
      logic dneg;
      logic dzero;
      logic opos;
      logic oneg;
      logic flag;
   } div_side_type;

   // Clamp a wide signed value to Q_W bits; the top bit reports clamping.
   function automatic logic [Q_W:0] sat_q(input logic signed [65:0] v);
      logic [Q_W:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, Q_MAX};
      end else if (v < SAT_LO) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b0, v[Q_W-1:0]};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/ray_tetrahedron_slab_test.sv */
// Top level: ray/tetrahedron slab test with four plane lanes and a merge unit.
//
//  channel | direction | handshake          | beat
//  req     | in        | req_valid/req_stall | ray_in_type (origin, direction)
//  rsp     | out       | rsp_valid/rsp_stall | ray_out_type (cut_length, saturated)
//  csr     | in        | csr_we              | csr_index, csr_wdata (64 bits)
//
// One ray per cycle while the output is not stalled; the depth comes mostly from the
// one-bit-per-stage divider in each lane. Every stage has its own valid bit and
// advances when the stage after it is empty or moving, so bubbles collapse while the
// output is stalled. Synchronous reset clears the valid bits and the matrix.
`default_nettype none
module ray_tetrahedron_slab_test (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  rts_pkg::ray_in_type                  req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output rts_pkg::ray_out_type                 rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [rts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [63:0]                     csr_wdata
);
   import rts_pkg::*;

   logic [3:0][3:0][Q_W-1:0] mat_ff;
   logic [STAGES-1:0]        vld_ff;
   logic [STAGES-1:0]        rdy;
   lane_res_type             lane_res[LANES];

   // Matrix registers; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= '0;
      end else if (csr_we && (csr_index < CSR_IDX_W'(CSR_COUNT))) begin
         mat_ff[csr_index[2:1]][{csr_index[0], 1'b0}]   <= csr_wdata[31:0];
         mat_ff[csr_index[2:1]][{csr_index[0], 1'b1}]   <= csr_wdata[63:32];
      end
   end

   // Stage ready chain from the output back
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[STAGES-1];

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [3:0][Q_W-1:0] col;
      always_comb begin
         for (int i = 0; i < 4; i++) col[i] = mat_ff[i][j];
      end
      rts_lane u_lane (
         .clock (clock),
         .en    (rdy[LANE_DEPTH-1:0]),
         .ray   (req_data),
         .col   (col),
         .res   (lane_res[j])
      );
   end

   rts_merge u_merge (
      .clock (clock),
      .en    (rdy[STAGES-1:STAGES-2]),
      .lanes (lane_res),
      .rsp   (rsp_data)
   );
endmodule
`default_nettype wire

/* hw/rtl/rts_div.sv */
// Pipelined restoring divider: one quotient bit per stage, then sign, clamp and zero-divisor override.
`default_nettype none
module rts_div (
   input  wire logic                            clock,
   input  wire logic [rts_pkg::NUM_W+1:0]       en,
   input  wire logic signed [rts_pkg::Q_W-1:0]  o,
   input  wire logic signed [rts_pkg::Q_W-1:0]  d,
   input  wire logic                            tflag,
   output rts_pkg::lane_res_type                res
);
   import rts_pkg::*;

   logic [Q_W-1:0]   rem_ff [NUM_W+1];
   logic [NUM_W-1:0] num_ff [NUM_W+1];
   logic [NUM_W-1:0] quo_ff [NUM_W+1];
   logic [Q_W-1:0]   dm_ff  [NUM_W+1];
   div_side_type     side_ff[NUM_W+1];
   lane_res_type     res_ff;

   logic [Q_W-1:0] om_in;
   logic [Q_W-1:0] dm_in;
   div_side_type   side_in;

   // Take magnitudes and classify the operands
   always_comb begin
      om_in = o[Q_W-1] ? (~o + 1'b1) : o;
      dm_in = d[Q_W-1] ? (~d + 1'b1) : d;
      side_in.qneg  = o[Q_W-1] ^ d[Q_W-1];
      side_in.dneg  = d[Q_W-1];
      side_in.dzero = (d == '0);
      side_in.opos  = !o[Q_W-1] && (o != '0);
      side_in.oneg  = o[Q_W-1];
      side_in.flag  = tflag;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= '0;
         num_ff[0]  <= {om_in, {FRAC_BITS{1'b0}}};
         quo_ff[0]  <= '0;
         dm_ff[0]   <= dm_in;
         side_ff[0] <= side_in;
      end
   end

   // One restoring step per stage
   for (genvar k = 1; k <= NUM_W; k++) begin : g_step
      logic [Q_W:0] trial;
      logic         ge;
      logic [Q_W:0] diff;
      always_comb begin
         trial = {rem_ff[k-1], num_ff[k-1][NUM_W-1]};
         ge    = (trial >= {1'b0, dm_ff[k-1]});
         diff  = trial - {1'b0, dm_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
            num_ff[k]  <= {num_ff[k-1][NUM_W-2:0], 1'b0};
            quo_ff[k]  <= {quo_ff[k-1][NUM_W-2:0], ge};
            dm_ff[k]   <= dm_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   logic signed [65:0] sv;
   logic [Q_W:0]       sat;
   lane_res_type       res_in;
   div_side_type       sd;

   // Apply sign, clamp, and override for a zero divisor
   always_comb begin
      sd = side_ff[NUM_W];
      sv = sd.qneg ? -$signed(66'(quo_ff[NUM_W])) : $signed(66'(quo_ff[NUM_W]));
      sat = sat_q(sv);
      res_in.dneg = sd.dneg;
      if (sd.dzero) begin
         if (sd.opos) begin
            res_in.q = Q_MAX;
            res_in.flag = 1'b1;
         end else if (sd.oneg) begin
            res_in.q = Q_MIN;
            res_in.flag = 1'b1;
         end else begin
            res_in.q = '0;
            res_in.flag = sd.flag;
         end
      end else begin
         res_in.q = sat[Q_W-1:0];
         res_in.flag = sd.flag | sat[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NUM_W+1]) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;
endmodule
`default_nettype wire

/* hw/rtl/rts_lane.sv */
// One plane lane: transform origin and direction by a matrix column, then divide.
`default_nettype none
module rts_lane (
   input  wire logic                               clock,
   input  wire logic [rts_pkg::LANE_DEPTH-1:0]     en,
   input  rts_pkg::ray_in_type                     ray,
   input  wire logic [3:0][rts_pkg::Q_W-1:0]       col,
   output rts_pkg::lane_res_type                   res
);
   import rts_pkg::*;

   logic signed [63:0]  po_ff[4];
   logic signed [63:0]  pd_ff[4];
   logic signed [64:0]  so_ff[2];
   logic signed [64:0]  sd_ff[2];
   logic signed [Q_W-1:0] o_ff;
   logic signed [Q_W-1:0] d_ff;
   logic                  tflag_ff;

   logic signed [Q_W-1:0] ov[4];
   logic signed [Q_W-1:0] dv[4];

   assign ov[0] = ray.orig_x;
   assign ov[1] = ray.orig_y;
   assign ov[2] = ray.orig_z;
   assign ov[3] = ray.orig_w;
   assign dv[0] = ray.dir_x;
   assign dv[1] = ray.dir_y;
   assign dv[2] = ray.dir_z;
   assign dv[3] = ray.dir_w;

   // Products of each component with its matrix element
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 4; i++) begin
            po_ff[i] <= ov[i] * $signed(col[i]);
            pd_ff[i] <= dv[i] * $signed(col[i]);
         end
      end
   end

   // Pairwise sums
   always_ff @(posedge clock) begin
      if (en[1]) begin
         so_ff[0] <= 65'(po_ff[0]) + 65'(po_ff[1]);
         so_ff[1] <= 65'(po_ff[2]) + 65'(po_ff[3]);
         sd_ff[0] <= 65'(pd_ff[0]) + 65'(pd_ff[1]);
         sd_ff[1] <= 65'(pd_ff[2]) + 65'(pd_ff[3]);
      end
   end

   logic signed [65:0] sum_o;
   logic signed [65:0] sum_d;
   logic [Q_W:0]       sat_o;
   logic [Q_W:0]       sat_d;

   // Final sum, floor shift and clamp
   always_comb begin
      sum_o = 66'(so_ff[0]) + 66'(so_ff[1]);
      sum_d = 66'(sd_ff[0]) + 66'(sd_ff[1]);
      sat_o = sat_q(sum_o >>> FRAC_BITS);
      sat_d = sat_q(sum_d >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         o_ff     <= sat_o[Q_W-1:0];
         d_ff     <= sat_d[Q_W-1:0];
         tflag_ff <= sat_o[Q_W] | sat_d[Q_W];
      end
   end

   rts_div u_div (
      .clock (clock),
      .en    (en[LANE_DEPTH-1:3]),
      .o     (o_ff),
      .d     (d_ff),
      .tflag (tflag_ff),
      .res   (res)
   );
endmodule
`default_nettype wire

/* hw/rtl/rts_merge.sv */
// Merge lanes: entry minimum, exit maximum, then the clamped difference.
`default_nettype none
module rts_merge (
   input  wire logic                  clock,
   input  wire logic [1:0]            en,
   input  rts_pkg::lane_res_type      lanes[rts_pkg::LANES],
   output rts_pkg::ray_out_type       rsp
);
   import rts_pkg::*;

   logic signed [Q_W-1:0] entry_ff, exit_ff;
   logic                  flag_ff;
   logic signed [Q_W-1:0] entry_in, exit_in;
   logic                  flag_in;
   ray_out_type           rsp_ff;

   // Fold lane quotients into entry and exit bounds
   always_comb begin
      entry_in = Q_MAX;
      exit_in  = Q_MIN;
      flag_in  = 1'b0;
      for (int j = 0; j < LANES; j++) begin
         flag_in = flag_in | lanes[j].flag;
         if (lanes[j].dneg) begin
            if (lanes[j].q < entry_in) entry_in = lanes[j].q;
         end else begin
            if (lanes[j].q > exit_in) exit_in = lanes[j].q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
         flag_ff  <= flag_in;
      end
   end

   logic [Q_W:0] sat;

   always_comb begin
      sat = sat_q(66'(entry_ff) - 66'(exit_ff));
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en[1]) begin
         rsp_ff.cut_length <= sat[Q_W-1:0];
         rsp_ff.saturated  <= flag_ff | sat[Q_W];
      end
   end

   assign rsp = rsp_ff;
endmodule
`default_nettype wire

/* hw/rtl/rts_check.sv */
// Port checker for the slab test, bound to the top level.
`default_nettype none
module rts_check (
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_valid,
   input wire logic           req_stall,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input rts_pkg::ray_out_type rsp_data
);
   import rts_pkg::*;

   // A stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // With the output empty the pipeline must take input
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   // No result right after reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input stall only while the output is blocked
   a_back: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
endmodule

bind ray_tetrahedron_slab_test rts_check u_chk (.*);
`default_nettype wire

/* verif/testbench.sv */
// Testbench for the ray/tetrahedron slab test: directed rays, then random rays per matrix.
module testbench;
   import rts_pkg::*;

   localparam int LATENCY = NUM_W + 7;
   localparam int LONG_HOLD = 600;
   localparam int RAND_PER_SET = 170;

   typedef enum int {SET_ZERO, SET_IDENT, SET_EXTREME, SET_FULL, SET_SMALL, SET_SPARSE}
      matrix_set_type;

   typedef struct {
      matrix_set_type set;
      ray_in_type  ray;
      bit          pinned;
      ray_out_type cut;
   } ray_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   ray_in_type  req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   ray_out_type rsp_data;
   logic        csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_wdata;

   logic signed [Q_W-1:0] plane [4][4];
   ray_out_type cut_queue [$];
   int errors = 0;
   bit steady = 1'b0;
   bit hold_long = 1'b0;

   ray_tetrahedron_slab_test dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   // Clamp to Q_W bits, raising the flag on clamping.
   function automatic longint clamp_q(input logic signed [65:0] v, inout bit flag);
      if (v > SAT_HI) begin
         flag = 1'b1;
         return longint'(Q_MAX);
      end else if (v < SAT_LO) begin
         flag = 1'b1;
         return longint'(Q_MIN);
      end
      return longint'(v);
   endfunction

   // Predict the cut length of one ray against the shadow matrix.
   function automatic ray_out_type predict_cut(input ray_in_type r);
      logic signed [Q_W-1:0] ov [4];
      logic signed [Q_W-1:0] dv [4];
      logic signed [65:0] osum, dsum, p;
      longint o, d, q, entry, exitb;
      bit flag;
      ray_out_type res;
      ov = '{r.orig_x, r.orig_y, r.orig_z, r.orig_w};
      dv = '{r.dir_x, r.dir_y, r.dir_z, r.dir_w};
      entry = longint'(Q_MAX);
      exitb = longint'(Q_MIN);
      flag = 1'b0;
      for (int j = 0; j < 4; j++) begin
         osum = '0;
         dsum = '0;
         for (int i = 0; i < 4; i++) begin
            p = longint'(ov[i]) * longint'(plane[i][j]);
            osum += p;
            p = longint'(dv[i]) * longint'(plane[i][j]);
            dsum += p;
         end
         o = clamp_q(osum >>> FRAC_BITS, flag);
         d = clamp_q(dsum >>> FRAC_BITS, flag);
         // zero divisor stands in for infinity
         if (d == 0) begin
            if (o != 0) flag = 1'b1;
            q = (o > 0) ? longint'(Q_MAX) : (o < 0) ? longint'(Q_MIN) : 0;
         end else begin
            q = clamp_q((o * (longint'(1) << FRAC_BITS)) / d, flag);
         end
         if (d < 0) begin
            if (q < entry) entry = q;
         end else begin
            if (q > exitb) exitb = q;
         end
      end
      res.cut_length = Q_W'(clamp_q(entry - exitb, flag));
      res.saturated = flag;
      return res;
   endfunction

   function automatic logic signed [Q_W-1:0] draw_elem(input matrix_set_type set, int i, int j);
      case (set)
         SET_ZERO:    return '0;
         SET_IDENT:   return (i == j) ? Q_W'(1 << FRAC_BITS) : '0;
         SET_EXTREME: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         SET_FULL:    return $urandom;
         SET_SMALL:   return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         default:     return $urandom_range(0, 1) ? '0 :
                             $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      endcase
   endfunction

   function automatic logic signed [Q_W-1:0] draw_comp(input bit wide);
      if (wide) return $urandom;
      if ($urandom_range(0, 4) == 0) return '0;
      return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
   endfunction

   function automatic ray_in_type make_ray(input logic signed [Q_W-1:0] ox, oy, oz, ow,
                                           dx, dy, dz, dw);
      return '{ox, oy, oz, ow, dx, dy, dz, dw};
   endfunction

   // Drop the offer, then wait out every outstanding beat and the pipeline depth.
   task automatic drain();
      req_valid <= 1'b0;
      while (cut_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Load a matrix through the csr port, plus one write to an unused index.
   task automatic load_matrix(input matrix_set_type set);
      logic signed [Q_W-1:0] m [4][4];
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            m[i][j] = draw_elem(set, i, j);
      for (int k = 0; k < CSR_COUNT; k++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= {m[k >> 1][(k & 1) * 2 + 1], m[k >> 1][(k & 1) * 2]};
         @(posedge clock);
      end
      csr_index <= CSR_IDX_W'($urandom_range(CSR_COUNT, (1 << CSR_IDX_W) - 1));
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
      plane = m;
   endtask

   // Offer one ray, hold it until accepted, then record its expected cut.
   task automatic send_ray(input ray_in_type r, bit pinned, ray_out_type cut);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      cut_queue.push_back(pinned ? cut : predict_cut(r));
   endtask

   // Stimulus
   initial begin
      ray_row_type steps [$];
      matrix_set_type cur;
      ray_out_type none;
      logic signed [Q_W-1:0] one;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            plane[i][j] = '0;
      none = '0;
      one = Q_W'(1 << FRAC_BITS);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset matrix: every plane is 0/0, so entry stays at the top, exit at zero
      steps.push_back('{SET_ZERO, '0, 1'b1, '{Q_MAX, 1'b0}});
      steps.push_back('{SET_ZERO, {8{Q_MAX}}, 1'b1, '{Q_MAX, 1'b0}});
      steps.push_back('{SET_ZERO, {8{Q_MIN}}, 1'b1, '{Q_MAX, 1'b0}});
      steps.push_back('{SET_ZERO, {4{Q_MAX, Q_MIN}}, 1'b1, '{Q_MAX, 1'b0}});
      steps.push_back('{SET_ZERO, {8{32'hFFFF_FFFF}}, 1'b1, '{Q_MAX, 1'b0}});
      // identity: planes see the ray directly
      steps.push_back('{SET_IDENT, make_ray(one, 2*one, 3*one, 4*one, one, one, one, one),
                        1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(one, 2*one, 3*one, 4*one, -one, -one, -one,
                        -one), 1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(one, one, one, one, 0, 0, 0, 0), 1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(-one, -one, -one, -one, 0, 0, 0, 0), 1'b0,
                        none});
      steps.push_back('{SET_IDENT, make_ray(0, one, -one, 0, 0, 0, 0, 0), 1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, -1, 1, -1), 1'b0,
                        none});
      steps.push_back('{SET_IDENT, make_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, -1, -1, -1, -1),
                        1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(3*one, -5*one, 7*one, -one, -one, 2*one,
                        -3*one, 4*one), 1'b0, none});
      steps.push_back('{SET_IDENT, make_ray(one, one, one, one, Q_MIN, Q_MAX, Q_MIN, Q_MAX),
                        1'b0, none});
      steps.push_back('{SET_EXTREME, {8{Q_MAX}}, 1'b0, none});
      steps.push_back('{SET_EXTREME, {8{Q_MIN}}, 1'b0, none});
      steps.push_back('{SET_EXTREME, make_ray(Q_MAX, Q_MIN, 1, -1, Q_MIN, Q_MAX, -1, 1),
                        1'b0, none});

      // walk the directed rows, reloading the matrix when the row asks for another one
      cur = SET_ZERO;
      foreach (steps[n]) begin
         if (steps[n].set != cur) begin
            drain();
            cur = steps[n].set;
            load_matrix(cur);
         end
         send_ray(steps[n].ray, steps[n].pinned, steps[n].cut);
      end

      // random rays, one batch per matrix setting
      for (int s = SET_ZERO; s <= SET_SPARSE; s++) begin
         drain();
         req_valid <= 1'b0;
         load_matrix(matrix_set_type'(s));
         steady = (s == SET_SMALL);
         if (s == SET_FULL) hold_long = 1'b1;
         for (int n = 0; n < RAND_PER_SET; n++) begin
            bit wide;
            if (s == SET_SPARSE && n == RAND_PER_SET / 2) begin
               req_valid <= 1'b0;
               while (cut_queue.size() != 0) @(posedge clock);
            end
            wide = ($urandom_range(0, 9) < 4);
            send_ray(make_ray(draw_comp(wide), draw_comp(wide), draw_comp(wide),
                              draw_comp(wide), draw_comp(wide), draw_comp(wide),
                              draw_comp(wide), draw_comp(wide)), 1'b0, none);
         end
         steady = 1'b0;
      end
      drain();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Result side: random stall stretches, one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end
         n = steady ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each accepted beat against the oldest expected cut
   always @(posedge clock) begin
      ray_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cut_queue.size() == 0) begin
            $error("unexpected beat: cut_length %0d saturated %0d",
                   rsp_data.cut_length, rsp_data.saturated);
            errors++;
         end else begin
            want = cut_queue.pop_front();
            if (rsp_data.cut_length !== want.cut_length) begin
               $error("cut_length: expected %0d, got %0d", want.cut_length,
                      rsp_data.cut_length);
               errors++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated,
                      rsp_data.saturated);
               errors++;
            end
         end
      end
   end

endmodule
